/* rtl/core/tsp_pkg.sv */
`timescale 1ns / 1ps

package tsp_pkg;

   localparam int CHAR_W     = 8;
   localparam int VAL_W      = 14;
   localparam int NUM_FIELDS = 7;
   localparam int RSP_DATA_W = 64;

   localparam logic [CHAR_W-1:0] TERM_CHAR = 8'h7E;
   localparam logic [VAL_W-1:0]  SAT_MAX   = 14'd16383;

   localparam logic [VAL_W-1:0] YEAR_MIN   = 14'd1900;
   localparam logic [VAL_W-1:0] YEAR_MAX   = 14'd9999;
   localparam logic [VAL_W-1:0] HOUR_MAX   = 14'd23;
   localparam logic [VAL_W-1:0] MINSEC_MAX = 14'd59;
   localparam logic [VAL_W-1:0] MSEC_MAX   = 14'd999;

   // field slots in arrival order
   localparam logic [2:0] FLD_DAY   = 3'd0;
   localparam logic [2:0] FLD_MONTH = 3'd1;
   localparam logic [2:0] FLD_YEAR  = 3'd2;
   localparam logic [2:0] FLD_HOUR  = 3'd3;
   localparam logic [2:0] FLD_MIN   = 3'd4;
   localparam logic [2:0] FLD_SEC   = 3'd5;
   localparam logic [2:0] FLD_MSEC  = 3'd6;
   localparam logic [2:0] FLD_PAST  = 3'd7;

   typedef enum logic [1:0] {
      PH_BLANK  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      FP_NONE = 2'd0,
      FP_GOOD = 2'd1,
      FP_BAD  = 2'd2
   } punct_type;

   function automatic logic is_sep(input logic [CHAR_W-1:0] c);
      return (c == "-") || (c == "_") || (c == ":") || (c == ".") || (c == ",");
   endfunction

   function automatic logic is_punct(input logic [CHAR_W-1:0] c);
      return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // x mod 25 for x < 256: quotient by reciprocal 41/1024, exact in this range
   function automatic logic [4:0] mod25(input logic [7:0] x);
      logic [13:0] prod;
      logic [3:0]  quo;
      logic [7:0]  sub;
      prod = 14'(x) * 14'd41;
      quo  = prod[13:10];
      sub  = 8'(quo * 8'd25);
      return 5'(x - sub);
   endfunction

   // first character in the low byte
   function automatic logic [23:0] pack3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      return {c, b, a};
   endfunction

   function automatic logic [3:0] month_by_name(input logic [23:0] w);
      logic [3:0] m;
      m = 4'd0;
      if (w == pack3("J", "A", "N")) m = 4'd1;
      if (w == pack3("F", "E", "B")) m = 4'd2;
      if (w == pack3("M", "A", "R")) m = 4'd3;
      if (w == pack3("A", "P", "R")) m = 4'd4;
      if (w == pack3("M", "A", "Y")) m = 4'd5;
      if (w == pack3("J", "U", "N")) m = 4'd6;
      if (w == pack3("J", "U", "L")) m = 4'd7;
      if (w == pack3("A", "U", "G")) m = 4'd8;
      if (w == pack3("S", "E", "P")) m = 4'd9;
      if (w == pack3("O", "C", "T")) m = 4'd10;
      if (w == pack3("N", "O", "V")) m = 4'd11;
      if (w == pack3("D", "E", "C")) m = 4'd12;
      return m;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the months before m, common year
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

/* rtl/core/timestamp_string_parser.sv */
`timescale 1ns / 1ps
// Date-time string parser.
// Input channel req_*: one character per beat in req_tdata[7:0]; '~' closes
// the string. Fields (day, month, year, hour, minute, second, millisecond)
// are split at - _ : . and commas; the month may be digits or a three-letter
// name in any letter case. Each field keeps its first FIELD_CHARS characters.
// Result channel rsp_*: one beat per closing '~', none for other characters.
// rsp_tuser carries the valid flag; when it is low every field in rsp_tdata
// is zero.
// Latency: the result beat appears in the cycle after the '~' beat is taken.
// Throughput: one character per cycle while result beats are taken; each
// character only touches small accumulators (constant multiply by ten), and
// the end-of-string checks fit between parser state and result register.
// Reset clears the parser and drops any pending result. The parser also
// returns to its reset state after each '~'.
// When the receiver stalls, the result register holds its beat and req_tready
// drops until that beat is taken; input is accepted again in the same cycle
// the result leaves.

module timestamp_string_parser #(
   parameter int FIELD_CHARS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tsp_pkg::CHAR_W-1:0]        req_tdata,   // [7:0] char_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [13:0] year, [17:14] month, [22:18] day, [31:23] day_of_year,
   // [36:32] hour, [42:37] minute, [48:43] second, [58:49] millisecond,
   // [63:59] zero
   output logic [tsp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser    // [0] valid_res
);
   import tsp_pkg::*;

   localparam int CNT_W = $clog2(FIELD_CHARS + 1);

   // ---------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------
   logic [2:0]       field_idx_ff, field_idx_in;
   logic [CNT_W-1:0] char_cnt_ff, char_cnt_in;
   phase_type        phase_ff, phase_in;
   logic [VAL_W-1:0] field_val_ff [NUM_FIELDS];
   logic [VAL_W-1:0] field_val_in [NUM_FIELDS];
   logic [23:0]      mon_letters_ff, mon_letters_in;
   logic             mon_numeric_ff, mon_numeric_in;
   punct_type        punct_ff, punct_in;
   logic             last_dot_ff, last_dot_in;
   logic [CNT_W-1:0] msec_cnt_ff, msec_cnt_in;
   logic [4:0]       year_mod25_ff, year_mod25_in;   // feeds the leap rule

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tuser_ff, rsp_tuser_in;

   logic             req_fire;
   logic             is_term;
   logic [CHAR_W-1:0] ch;

   assign ch         = req_tdata;
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_term    = (ch == TERM_CHAR);

   // ---------------------------------------------------------------
   // Per-character update
   // ---------------------------------------------------------------
   logic             take;
   logic             accum;
   logic [VAL_W-1:0] cur_val;
   logic [3:0]       digit;
   logic [17:0]      acc_sum;
   logic [VAL_W-1:0] acc_val;
   logic [7:0]       mod_arg;
   logic [CHAR_W-1:0] upper_ch;

   always_comb begin
      take    = (field_idx_ff != FLD_PAST) && (char_cnt_ff < CNT_W'(FIELD_CHARS));
      cur_val = (field_idx_ff != FLD_PAST) ? field_val_ff[field_idx_ff] : '0;
      digit   = 4'(ch - "0");
      acc_sum = {cur_val, 3'b000} + {3'b000, cur_val, 1'b0} + 18'(digit);
      acc_val = (acc_sum > 18'(SAT_MAX)) ? SAT_MAX : acc_sum[VAL_W-1:0];
      mod_arg = 8'({year_mod25_ff, 3'b000} + {year_mod25_ff, 1'b0}) + 8'(digit);
      upper_ch = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;

      // digit accept per number phase; leading blanks hold the phase, a leading '+' moves it to the sign phase
      accum    = 1'b0;
      phase_in = phase_ff;
      case (phase_ff)
         PH_BLANK: begin
            if (is_blank(ch)) begin
               phase_in = PH_BLANK;
            end else if (ch == "+") begin
               phase_in = PH_SIGN;
            end else if (is_digit(ch)) begin
               accum    = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (is_digit(ch)) begin
               accum    = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end
         default: phase_in = PH_DONE;
      endcase

      field_idx_in   = field_idx_ff;
      char_cnt_in    = char_cnt_ff;
      field_val_in   = field_val_ff;
      mon_letters_in = mon_letters_ff;
      mon_numeric_in = mon_numeric_ff;
      punct_in       = punct_ff;
      last_dot_in    = last_dot_ff;
      msec_cnt_in    = msec_cnt_ff;
      year_mod25_in  = year_mod25_ff;

      if (req_fire && !is_term) begin
         if (punct_ff == FP_NONE && is_punct(ch)) begin
            punct_in = (ch == "," || ch == "-") ? FP_GOOD : FP_BAD;
         end
         if (is_sep(ch)) begin
            // close the field, open the next
            last_dot_in = (ch == ".");
            if (field_idx_ff != FLD_PAST) field_idx_in = field_idx_ff + 3'd1;
            char_cnt_in = '0;
            phase_in    = PH_BLANK;
         end else if (take) begin
            if (field_idx_ff == FLD_MONTH) begin
               if (char_cnt_ff == '0) mon_numeric_in = is_digit(ch);
               if (char_cnt_ff < CNT_W'(3)) begin
                  case (char_cnt_ff[1:0])
                     2'd0:    mon_letters_in[7:0]   = mon_letters_ff[7:0]   | upper_ch;
                     2'd1:    mon_letters_in[15:8]  = mon_letters_ff[15:8]  | upper_ch;
                     default: mon_letters_in[23:16] = mon_letters_ff[23:16] | upper_ch;
                  endcase
               end
            end
            if (accum) begin
               field_val_in[field_idx_ff] = acc_val;
               if (field_idx_ff == FLD_YEAR) year_mod25_in = mod25(mod_arg);
            end
            char_cnt_in = char_cnt_ff + CNT_W'(1);
            if (field_idx_ff == FLD_MSEC) msec_cnt_in = char_cnt_ff + CNT_W'(1);
         end else begin
            phase_in = phase_ff;
         end
      end else begin
         phase_in = phase_ff;
      end
   end

   // ---------------------------------------------------------------
   // End-of-string checks, evaluated on the state before the '~'
   // ---------------------------------------------------------------
   logic [VAL_W-1:0] day_v, year_v, hour_v, min_v, sec_v, msec_v, mon_v;
   logic             div4, div100, div400, leap;
   logic             msec_ok, ok_fields, ok;
   logic [3:0]       mon4;
   logic [9:0]       msec_out;
   logic [8:0]       doy;

   always_comb begin
      day_v  = field_val_ff[FLD_DAY];
      year_v = field_val_ff[FLD_YEAR];
      hour_v = field_val_ff[FLD_HOUR];
      min_v  = field_val_ff[FLD_MIN];
      sec_v  = field_val_ff[FLD_SEC];
      msec_v = field_val_ff[FLD_MSEC];
      mon_v  = mon_numeric_ff ? field_val_ff[FLD_MONTH]
                              : VAL_W'(month_by_name(mon_letters_ff));
      mon4   = mon_v[3:0];

      div4   = (year_v[1:0] == 2'd0);
      div100 = div4 && (year_mod25_ff == 5'd0);
      div400 = (year_v[3:0] == 4'd0) && (year_mod25_ff == 5'd0);
      leap   = (div4 && !div100) || div400;

      // scaled millisecond limits replace a wide multiply in the check
      if (last_dot_ff && msec_cnt_ff == CNT_W'(1)) begin
         msec_ok  = (msec_v <= VAL_W'(9));
         msec_out = 10'({6'd0, msec_v[3:0]} * 10'd100);
      end else if (last_dot_ff && msec_cnt_ff == CNT_W'(2)) begin
         msec_ok  = (msec_v <= VAL_W'(99));
         msec_out = 10'({3'd0, msec_v[6:0]} * 10'd10);
      end else begin
         msec_ok  = (msec_v <= MSEC_MAX);
         msec_out = msec_v[9:0];
      end

      ok_fields = (punct_ff == FP_GOOD) && (year_v >= YEAR_MIN) && (year_v <= YEAR_MAX) &&
                  (mon_v >= VAL_W'(1)) && (mon_v <= VAL_W'(12)) &&
                  (hour_v <= HOUR_MAX) && (min_v <= MINSEC_MAX) &&
                  (sec_v <= MINSEC_MAX) && msec_ok;
      ok  = ok_fields && (day_v >= VAL_W'(1)) &&
            (day_v <= VAL_W'(month_len(mon4, leap)));
      doy = days_before(mon4) + 9'(day_v[4:0]) + 9'(leap && (mon4 > 4'd2));

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (req_fire && is_term) begin
         rsp_tvalid_in = 1'b1;
         rsp_tuser_in  = ok;
         rsp_tdata_in  = '0;
         if (ok) begin
            rsp_tdata_in[13:0]  = year_v;
            rsp_tdata_in[17:14] = mon4;
            rsp_tdata_in[22:18] = day_v[4:0];
            rsp_tdata_in[31:23] = doy;
            rsp_tdata_in[36:32] = hour_v[4:0];
            rsp_tdata_in[42:37] = min_v[5:0];
            rsp_tdata_in[48:43] = sec_v[5:0];
            rsp_tdata_in[58:49] = msec_out;
         end
      end
   end

   // ---------------------------------------------------------------
   // Registers; '~' returns the parser to its reset state
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || (req_fire && is_term)) begin
         field_idx_ff   <= FLD_DAY;
         char_cnt_ff    <= '0;
         phase_ff       <= PH_BLANK;
         for (int i = 0; i < NUM_FIELDS; i++) field_val_ff[i] <= '0;
         mon_letters_ff <= '0;
         mon_numeric_ff <= 1'b0;
         punct_ff       <= FP_NONE;
         last_dot_ff    <= 1'b0;
         msec_cnt_ff    <= '0;
         year_mod25_ff  <= '0;
      end else begin
         field_idx_ff   <= field_idx_in;
         char_cnt_ff    <= char_cnt_in;
         phase_ff       <= phase_in;
         field_val_ff   <= field_val_in;
         mon_letters_ff <= mon_letters_in;
         mon_numeric_ff <= mon_numeric_in;
         punct_ff       <= punct_in;
         last_dot_ff    <= last_dot_in;
         msec_cnt_ff    <= msec_cnt_in;
         year_mod25_ff  <= year_mod25_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_term_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_term |=> rsp_tvalid_ff)
      else $error("terminator did not produce a result beat");

   a_beat_from_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(req_fire && is_term))
      else $error("result beat without a terminator");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_term |=> field_idx_ff == FLD_DAY && char_cnt_ff == '0 &&
                              punct_ff == FP_NONE)
      else $error("parser state not cleared after terminator");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tuser_ff |-> rsp_tdata_ff == '0)
      else $error("invalid result carries nonzero fields");

   a_valid_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff |-> rsp_tdata_ff[17:14] != 4'd0 &&
         rsp_tdata_ff[17:14] <= 4'd12 && rsp_tdata_ff[22:18] != 5'd0 &&
         rsp_tdata_ff[31:23] != 9'd0)
      else $error("valid result out of range");

endmodule
